// ===== hw/rtl/rmq_pkg.sv =====
// shared types and constants for the rotation matrix to quaternion block
`timescale 1ns / 1ps
`default_nettype none
package rmq_pkg;

  localparam int RMQ_FRAC_BITS = 14;   // default fraction bits
  localparam int RMQ_MW        = 16;   // matrix entry width
  localparam int RMQ_QW        = 16;   // quaternion component width
  localparam int RMQ_NW        = 17;   // numerator width (sum of two entries)
  localparam int RMQ_DQW       = 17;   // divider quotient width
  localparam int RMQ_DIV_LAT   = RMQ_DQW + 1;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;

  // sideband that rides along the square root stages
  typedef struct packed {
    logic                      vld;
    branch_t                   br;
    logic                      degen;
    logic [2:0][RMQ_NW-1:0]    n;
  } rmq_side_a_t;

  // sideband that rides along the divider stages
  typedef struct packed {
    logic              vld;
    branch_t           br;
    logic              degen;
    logic [RMQ_QW-1:0] diag;
  } rmq_side_b_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rotation_matrix_to_quaternion.sv =====
// top level: rotation matrix to unit quaternion, four-branch method, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
// Takes one 3x3 matrix of signed fixed-point entries per item and returns the
// quaternion (w, x, y, z) in the same format, the branch used (trace positive,
// or the largest diagonal entry) and a degenerate flag set when the radicand is
// not positive, in which case all components are zero. A new item is taken in
// every cycle unless the output stalls. SW is the square root width (18 at 14
// fraction bits). The square root produces one result bit per stage and each
// of the three dividers one quotient bit per stage after its first stage,
// which sets the depth. The whole pipeline advances whenever the output register
// is empty or being taken, so a stall holds every stage in place.
module rotation_matrix_to_quaternion #(
  parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each)
  input  wire logic [143:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // q_w, q_x, q_y, q_z (16 bits each)
  output logic [63:0]       out_tdata,
  // branch_taken (2 bits), degenerate
  output logic [2:0]        out_tuser
);
  import rmq_pkg::*;

  // radicand width, shifted radicand width, root width
  localparam int RW = ((FRAC_BITS > 17) ? FRAC_BITS : 17) + 3;
  localparam int VW = RW - 1 + FRAC_BITS + 2;
  localparam int SW = (VW + 1) / 2;

  logic en;
  logic out_vld_r;
  assign en         = !out_vld_r || out_tready;
  assign in_tready  = en;
  assign out_tvalid = out_vld_r;

  // ---- stage a: branch choice, radicand, numerators
  logic signed [RMQ_MW-1:0] m [9];
  for (genvar k = 0; k < 9; k++) begin : g_unpack
    assign m[k] = $signed(in_tdata[RMQ_MW*k +: RMQ_MW]);
  end

  logic signed [RW-1:0] e00, e11, e22, one, trace, rad_nxt;
  logic signed [RMQ_NW-1:0] d21_12, d02_20, d10_01, s01_10, s02_20, s12_21;
  rmq_side_a_t side_a_nxt;

  assign e00 = RW'(m[0]);
  assign e11 = RW'(m[4]);
  assign e22 = RW'(m[8]);
  assign one = RW'(1) <<< FRAC_BITS;
  assign trace = e00 + e11 + e22;
  assign d21_12 = RMQ_NW'(m[7]) - RMQ_NW'(m[5]);
  assign d02_20 = RMQ_NW'(m[2]) - RMQ_NW'(m[6]);
  assign d10_01 = RMQ_NW'(m[3]) - RMQ_NW'(m[1]);
  assign s01_10 = RMQ_NW'(m[1]) + RMQ_NW'(m[3]);
  assign s02_20 = RMQ_NW'(m[2]) + RMQ_NW'(m[6]);
  assign s12_21 = RMQ_NW'(m[5]) + RMQ_NW'(m[7]);

  always_comb begin
    side_a_nxt.vld = in_tvalid;
    if (trace > 0) begin
      side_a_nxt.br = BR_TRACE;
      rad_nxt = trace + one;
      side_a_nxt.n = {d10_01, d02_20, d21_12};
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      side_a_nxt.br = BR_X;
      rad_nxt = one + e00 - e11 - e22;
      side_a_nxt.n = {s02_20, s01_10, d21_12};
    end else if (m[4] > m[8]) begin
      side_a_nxt.br = BR_Y;
      rad_nxt = one + e11 - e00 - e22;
      side_a_nxt.n = {s12_21, s01_10, d02_20};
    end else begin
      side_a_nxt.br = BR_Z;
      rad_nxt = one + e22 - e00 - e11;
      side_a_nxt.n = {s12_21, s02_20, d10_01};
    end
    side_a_nxt.degen = (rad_nxt <= 0);
  end

  rmq_side_a_t side_a_r;
  logic [VW-1:0] v_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_a_r.vld <= 1'b0;
    end else if (en) begin
      side_a_r <= side_a_nxt;
      // radicand scaled by 2^(frac+2); zero when it is not positive
      v_r <= side_a_nxt.degen ? '0 : (VW'(rad_nxt[RW-2:0]) << (FRAC_BITS + 2));
    end
  end

  // ---- square root stages, sideband delayed alongside
  logic [SW-1:0] s_root;
  rmq_sqrt_pipe #(.VW(VW), .SW(SW)) u_sqrt (
    .clk (clk),
    .en  (en),
    .v   (v_r),
    .s   (s_root)
  );

  rmq_side_a_t sa_r [SW];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SW; i++) sa_r[i].vld <= 1'b0;
    end else if (en) begin
      sa_r[0] <= side_a_r;
      for (int i = 1; i < SW; i++) sa_r[i] <= sa_r[i-1];
    end
  end

  // diagonal component: s/4 rounded half up, saturated
  logic [SW:0]  diag_full;
  rmq_side_b_t  side_b_nxt;
  assign diag_full = (SW'(s_root) + (SW+1)'(2)) >> 2;
  always_comb begin
    side_b_nxt.vld   = sa_r[SW-1].vld;
    side_b_nxt.br    = sa_r[SW-1].br;
    side_b_nxt.degen = sa_r[SW-1].degen;
    if (diag_full > (SW+1)'(32767)) side_b_nxt.diag = 16'h7fff;
    else side_b_nxt.diag = diag_full[RMQ_QW-1:0];
  end

  // ---- three dividers for the off-diagonal components
  logic [RMQ_DQW-1:0] dq   [3];
  logic               dovf [3];
  logic               dneg [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    rmq_div_pipe #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div (
      .clk (clk),
      .en  (en),
      .num (sa_r[SW-1].n[k]),
      .s   (s_root),
      .q   (dq[k]),
      .ovf (dovf[k]),
      .neg (dneg[k])
    );
  end

  rmq_side_b_t sb_r [RMQ_DIV_LAT];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < RMQ_DIV_LAT; i++) sb_r[i].vld <= 1'b0;
    end else if (en) begin
      sb_r[0] <= side_b_nxt;
      for (int i = 1; i < RMQ_DIV_LAT; i++) sb_r[i] <= sb_r[i-1];
    end
  end

  // ---- output stage: sign, saturation, placement by branch
  logic [RMQ_QW-1:0] c [3];
  for (genvar k = 0; k < 3; k++) begin : g_sat
    always_comb begin
      if (!dneg[k]) begin
        if (dovf[k] || dq[k] > RMQ_DQW'(32767)) c[k] = 16'h7fff;
        else c[k] = dq[k][RMQ_QW-1:0];
      end else begin
        if (dovf[k] || dq[k] > RMQ_DQW'(32768)) c[k] = 16'h8000;
        else c[k] = RMQ_QW'(-dq[k]);
      end
    end
  end

  rmq_side_b_t       sb_last;
  logic [63:0]       qd_nxt;
  logic [RMQ_QW-1:0] dg;
  assign sb_last = sb_r[RMQ_DIV_LAT-1];
  assign dg      = sb_last.diag;
  always_comb begin
    case (sb_last.br)
      BR_TRACE: qd_nxt = {c[2], c[1], c[0], dg};
      BR_X:     qd_nxt = {c[2], c[1], dg, c[0]};
      BR_Y:     qd_nxt = {c[2], dg, c[1], c[0]};
      BR_Z:     qd_nxt = {dg, c[2], c[1], c[0]};
      default:  qd_nxt = '0;
    endcase
    if (sb_last.degen) qd_nxt = '0;
  end

  logic [63:0] out_data_r;
  logic [2:0]  out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r  <= sb_last.vld;
      out_data_r <= qd_nxt;
      out_user_r <= {sb_last.degen, sb_last.br};
    end
  end

  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_sqrt_pipe.sv =====
// pipelined integer square root, one result bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rmq_sqrt_pipe #(
  parameter int VW = 35,
  parameter int SW = (VW + 1) / 2
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [VW-1:0] v,
  output logic      [SW-1:0] s
);
  localparam int TW = 2 * SW + 1;

  logic [VW-1:0] rem_r  [SW];
  logic [SW-1:0] root_r [SW];

  for (genvar j = 0; j < SW; j++) begin : g_stage
    localparam int I = SW - 1 - j;
    logic [TW-1:0] rem_in, root_in, t, rem_nxt;
    logic [SW-1:0] root_nxt;
    if (j == 0) begin : g_first
      assign rem_in  = TW'(v);
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = TW'(rem_r[j-1]);
      assign root_in = TW'(root_r[j-1]);
    end
    // trial term (2*root + 2^i) * 2^i
    assign t = (root_in << (I + 1)) + (TW'(1) << (2 * I));
    always_comb begin
      if (rem_in >= t) begin
        rem_nxt  = rem_in - t;
        root_nxt = SW'(root_in) | (SW'(1) << I);
      end else begin
        rem_nxt  = rem_in;
        root_nxt = SW'(root_in);
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= VW'(rem_nxt);
        root_r[j] <= root_nxt;
      end
    end
  end

  assign s = root_r[SW-1];
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_div_pipe.sv =====
// pipelined rounded fixed-point divide, one quotient bit per stage after the first
`timescale 1ns / 1ps
`default_nettype none
module rmq_div_pipe #(
  parameter int FRAC_BITS = rmq_pkg::RMQ_FRAC_BITS,
  parameter int SW        = 18
) (
  input  wire logic                          clk,
  input  wire logic                          en,
  input  wire logic [rmq_pkg::RMQ_NW-1:0]    num,
  input  wire logic [SW-1:0]                 s,
  output logic      [rmq_pkg::RMQ_DQW-1:0]   q,
  output logic                               ovf,
  output logic                               neg
);
  import rmq_pkg::*;

  localparam int DW  = RMQ_NW + FRAC_BITS + 1;
  localparam int CW0 = (DW > SW + RMQ_DQW) ? DW : SW + RMQ_DQW;
  localparam int CW  = CW0 + 1;
  localparam int NS  = RMQ_DQW + 1;

  logic [CW-1:0]      rem_r [NS];
  logic [SW-1:0]      s_r   [NS];
  logic [RMQ_DQW-1:0] q_r   [NS];
  logic               ovf_r [NS];
  logic               neg_r [NS];

  // first stage: magnitude, rounding bias, overflow of the quotient range
  logic [RMQ_NW-1:0] mag;
  logic [CW-1:0]     d0;
  assign mag = num[RMQ_NW-1] ? RMQ_NW'(-num) : num;
  assign d0  = (CW'(mag) << FRAC_BITS) + CW'(s >> 1);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= d0;
      s_r[0]   <= s;
      q_r[0]   <= '0;
      ovf_r[0] <= d0 >= (CW'(s) << RMQ_DQW);
      neg_r[0] <= num[RMQ_NW-1];
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_step
    localparam int B = RMQ_DQW - k;
    logic [CW-1:0] t;
    assign t = CW'(s_r[k-1]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k]   <= s_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
        neg_r[k] <= neg_r[k-1];
        if (rem_r[k-1] >= t) begin
          rem_r[k] <= rem_r[k-1] - t;
          q_r[k]   <= q_r[k-1] | (RMQ_DQW'(1) << B);
        end else begin
          rem_r[k] <= rem_r[k-1];
          q_r[k]   <= q_r[k-1];
        end
      end
    end
  end

  assign q   = q_r[NS-1];
  assign ovf = ovf_r[NS-1];
  assign neg = neg_r[NS-1];
endmodule
`default_nettype wire

// ===== hw/rtl/rmq_checker.sv =====
// port-level checks for the rotation matrix to quaternion block
`timescale 1ns / 1ps
`default_nettype none
module rmq_props (
  input wire logic         clk,
  input wire logic         rst_n,
  input wire logic         in_tvalid,
  input wire logic         in_tready,
  input wire logic         out_tvalid,
  input wire logic         out_tready,
  input wire logic [63:0]  out_tdata,
  input wire logic [2:0]   out_tuser
);
  // a waiting result is never dropped
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // input side flows exactly when the output register can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready out of step with output");

  // degenerate items carry all-zero components
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tdata == 64'd0)
    else $error("degenerate item with nonzero components");

  // the diagonal component of the trace branch is never negative
  a_w_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] && out_tuser[1:0] == 2'd0 |-> !out_tdata[15])
    else $error("negative scalar part in trace branch");

  // nothing appears right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");
endmodule

bind rotation_matrix_to_quaternion rmq_props u_rmq_props (.*);
`default_nettype wire

// ===== test/rmq_checker.sv =====
// checker that predicts the quaternion for each accepted matrix and compares results
`timescale 1ns / 1ps
module rmq_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  output int           fail_count,
  output int           pending,
  output int           result_count,
  output int           degen_count,
  output int           branch_seen [4]
);
  import rmq_pkg::*;

  localparam int FB = RMQ_FRAC_BITS;

  typedef struct packed {
    logic [15:0] qw, qx, qy, qz;
    branch_t     br;
    logic        degen;
  } quat_t;

  quat_t expected_quats[$];

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? longint'(-num) : longint'(num);
    q = ((mag << FB) + den / 2) / den;
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic quat_t to_quaternion(logic [143:0] d);
    longint a[9];
    longint tr, rad, n[4], q[4];
    longint unsigned s;
    quat_t r;
    for (int i = 0; i < 9; i++) a[i] = longint'($signed(d[i*16 +: 16]));
    tr = a[0] + a[4] + a[8];
    if (tr > 0) begin
      r.br = BR_TRACE; rad = tr + (64'sd1 << FB);
      n[1] = a[7] - a[5]; n[2] = a[2] - a[6]; n[3] = a[3] - a[1];
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      r.br = BR_X; rad = (64'sd1 << FB) + a[0] - a[4] - a[8];
      n[0] = a[7] - a[5]; n[2] = a[1] + a[3]; n[3] = a[2] + a[6];
    end else if (a[4] > a[8]) begin
      r.br = BR_Y; rad = (64'sd1 << FB) + a[4] - a[0] - a[8];
      n[0] = a[2] - a[6]; n[1] = a[1] + a[3]; n[3] = a[5] + a[7];
    end else begin
      r.br = BR_Z; rad = (64'sd1 << FB) + a[8] - a[0] - a[4];
      n[0] = a[3] - a[1]; n[1] = a[2] + a[6]; n[2] = a[5] + a[7];
    end
    r.degen = (rad <= 0);
    for (int k = 0; k < 4; k++) q[k] = 0;
    if (!r.degen) begin
      s = int_sqrt(longint'(rad) << (FB + 2));
      for (int k = 0; k < 4; k++)
        q[k] = (k == int'(r.br)) ? longint'((s + 2) >> 2) : round_div(n[k], s);
    end
    r.qw = 16'(clamp16(q[0])); r.qx = 16'(clamp16(q[1]));
    r.qy = 16'(clamp16(q[2])); r.qz = 16'(clamp16(q[3]));
    return r;
  endfunction

  initial begin
    fail_count = 0; result_count = 0; degen_count = 0;
    for (int i = 0; i < 4; i++) branch_seen[i] = 0;
  end

  assign pending = expected_quats.size();

  always @(posedge clk) begin
    quat_t got, exp_q;
    if (rst_n && in_tvalid && in_tready) expected_quats.push_back(to_quaternion(in_tdata));
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
             branch_t'(out_tuser[1:0]), out_tuser[2]};
      result_count <= result_count + 1;
      if (expected_quats.size() == 0) begin
        fail_count <= fail_count + 1;
        if (fail_count < 10) $display("unexpected result %h", got);
      end else begin
        exp_q = expected_quats.pop_front();
        branch_seen[exp_q.br] <= branch_seen[exp_q.br] + 1;
        if (exp_q.degen) degen_count <= degen_count + 1;
        if (got !== exp_q) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10)
            $display("mismatch: exp w=%h x=%h y=%h z=%h br=%0d dg=%b got w=%h x=%h y=%h z=%h br=%0d dg=%b",
                     exp_q.qw, exp_q.qx, exp_q.qy, exp_q.qz, exp_q.br, exp_q.degen,
                     got.qw, got.qx, got.qy, got.qz, got.br, got.degen);
        end
      end
    end
  end
endmodule

// ===== test/rotation_matrix_to_quaternion_tb.sv =====
// testbench top: drives matrices into the block and reports the verdict
`timescale 1ns / 1ps
module rotation_matrix_to_quaternion_tb;
  localparam int ONE_Q = 1 << 14;
  localparam int LAT = 38;
  localparam int LIMIT = 400000;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic [143:0] in_tdata = '0;
  logic out_tready = 0;
  logic in_tready, out_tvalid;
  logic [63:0] out_tdata;
  logic [2:0] out_tuser;
  int fail_count, pending, result_count, degen_count;
  int branch_seen [4];
  int cycles = 0;
  bit no_idle = 0;      // stretch with neither side idling
  bit hold_off = 0;     // receiver holds off for a long stretch

  always #10 clk = ~clk;

  rotation_matrix_to_quaternion uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  rmq_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending, .result_count, .degen_count, .branch_seen
  );

  // timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stalls, a no-stall stretch and one long hold-off
  always @(posedge clk) begin
    if (!rst_n || hold_off) out_tready <= 0;
    else out_tready <= no_idle || ($urandom_range(99) >= 19);
  end

  initial begin
    wait (rst_n);
    repeat (300) @(posedge clk);
    hold_off = 1;
    repeat (200) @(posedge clk);
    hold_off = 0;
  end

  function automatic logic [143:0] pack_matrix(int e[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'(e[i]);
    return d;
  endfunction

  // near-rotation: positive diagonal in all slots or in one chosen slot, off-diagonals in -1..+1
  function automatic logic [143:0] rand_rotation_like();
    int e[9];
    int big;
    big = $urandom_range(3);
    for (int i = 0; i < 9; i++) e[i] = int'($urandom_range(2 * ONE_Q)) - ONE_Q;
    if (big == 0) begin
      e[0] = $urandom_range(ONE_Q); e[4] = $urandom_range(ONE_Q); e[8] = $urandom_range(ONE_Q);
    end else begin
      for (int i = 0; i < 3; i++) e[i*4] = -int'($urandom_range(ONE_Q));
      e[(big-1)*4] = $urandom_range(ONE_Q);
    end
    return pack_matrix(e);
  endfunction

  function automatic logic [143:0] rand_any();
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[i*16 +: 16] = 16'($urandom);
    return d;
  endfunction

  task automatic send(logic [143:0] d);
    while (!no_idle && $urandom_range(99) < 19) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  initial begin
    int e[9];
    int directed[$][9];
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: identity, 180 degree turns about each axis, ties, extremes, an all-zero matrix
    directed.push_back('{ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, ONE_Q});
    directed.push_back('{ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q});
    directed.push_back('{-ONE_Q, 0, 0, 0, ONE_Q, 0, 0, 0, -ONE_Q});
    directed.push_back('{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, ONE_Q});
    directed.push_back('{0, -ONE_Q, 0, ONE_Q, 0, 0, 0, 0, ONE_Q});
    directed.push_back('{-ONE_Q, 0, 0, 0, -ONE_Q, 0, 0, 0, -ONE_Q});
    directed.push_back('{0, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{-100, 5, 6, 7, -100, 8, 9, 10, -200});
    directed.push_back('{-200, 5, 6, 7, -100, 8, 9, 10, -100});
    directed.push_back('{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768});
    directed.push_back('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767});
    directed.push_back('{32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767});
    directed.push_back('{0, 32767, -32768, -32768, -32768, 32767, 32767, -32768, -32768});
    directed.push_back('{-32768, -32768, 32767, 32767, 0, -32768, -32768, 32767, -32768});
    directed.push_back('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768});
    directed.push_back('{1, 0, 0, 0, 0, 0, 0, 0, 0});
    directed.push_back('{-ONE_Q, 100, -100, 100, -ONE_Q, 100, -100, 100, 1});
    foreach (directed[i]) begin
      e = directed[i];
      send(pack_matrix(e));
    end
    // random: mostly rotation-like, some raw bit patterns; middle stretch has no idling
    for (int i = 0; i < 700; i++) begin
      no_idle = (i >= 300 && i < 400);
      send(($urandom_range(99) < 75) ? rand_rotation_like() : rand_any());
    end
    no_idle = 0;
    in_tvalid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    $display("checked %0d results: branches %0d/%0d/%0d/%0d, degenerate %0d",
             result_count, branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3],
             degen_count);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_sqrt_pipe.sv
hw/rtl/rmq_div_pipe.sv
hw/rtl/rotation_matrix_to_quaternion.sv
hw/rtl/rmq_checker.sv
test/rmq_checker.sv
test/rotation_matrix_to_quaternion_tb.sv
